// ----- design/mvt_pkg.sv -----
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the 4x4 vertex transform: transaction
// payloads, configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int COMP_W   = 32;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = COMP_W + COEF_W;
    localparam int NUM_ROWS = 4;
    localparam int NUM_COLS = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = NUM_ROWS * COEF_W;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_ZERO  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_ONE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_TWO   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_THREE = 8'd3;

    localparam logic [CFG_DATA_W-1:0] RST_COLUMN_ZERO  = 64'h0000_0000_0000_1000;
    localparam logic [CFG_DATA_W-1:0] RST_COLUMN_ONE   = 64'h0000_0000_1000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_COLUMN_TWO   = 64'h0000_1000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_COLUMN_THREE = 64'h1000_0000_0000_0000;

    localparam logic signed [COMP_W-1:0] COMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COMP_W-1:0] COMP_MIN = 32'sh8000_0000;

    typedef logic [NUM_COLS-1:0][COEF_W-1:0] t_coef_row;
    typedef logic [NUM_COLS-1:0][COMP_W-1:0] t_comp_vec;

    typedef struct packed {
        logic signed [COMP_W-1:0] x_in;
        logic signed [COMP_W-1:0] y_in;
        logic signed [COMP_W-1:0] z_in;
        logic signed [COMP_W-1:0] w_in;
        logic                     last_in;
    } t_vertex;

    typedef struct packed {
        logic signed [COMP_W-1:0] x_out;
        logic signed [COMP_W-1:0] y_out;
        logic signed [COMP_W-1:0] z_out;
        logic signed [COMP_W-1:0] w_out;
        logic                     saturated;
        logic                     last_out;
    } t_result;

endpackage

// ----- design/mvt_row.sv -----
// ----------------------------------------------------------------------------
// mvt_row
// One matrix row times the vertex: four products, a two-level registered
// adder tree and a saturating output register.
// ----------------------------------------------------------------------------
module mvt_row #(
    parameter int COEFF_FRAC_BITS = 12
) (
    input  logic                       i_clk,
    input  mvt_pkg::t_coef_row         i_coef,
    input  mvt_pkg::t_comp_vec         i_comp,
    output logic signed [31:0]         o_value,
    output logic                       o_clip
);
    import mvt_pkg::*;

    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [PROD_W-1:0] n_prod [NUM_COLS];
    logic signed [PROD_W-1:0] r_prod [NUM_COLS];
    logic signed [PAIR_W-1:0] n_pair [2];
    logic signed [PAIR_W-1:0] r_pair [2];
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [COMP_W-1:0] n_value;
    logic                     n_clip;
    logic signed [COMP_W-1:0] r_value;
    logic                     r_clip;

    always_comb begin
        for (int k = 0; k < NUM_COLS; k++) begin
            n_prod[k] = PROD_W'($signed(i_coef[k])) * PROD_W'($signed(i_comp[k]));
        end
        for (int p = 0; p < 2; p++) begin
            n_pair[p] = PAIR_W'(r_prod[2*p] >>> COEFF_FRAC_BITS)
                      + PAIR_W'(r_prod[2*p+1] >>> COEFF_FRAC_BITS);
        end
        n_sum = SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);
    end

    always_comb begin
        n_value = r_sum[COMP_W-1:0];
        n_clip  = 1'b0;
        if (r_sum[SUM_W-1:COMP_W-1] != '0 && r_sum[SUM_W-1:COMP_W-1] != '1) begin
            n_clip  = 1'b1;
            n_value = r_sum[SUM_W-1] ? COMP_MIN : COMP_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_pair  <= n_pair;
        r_sum   <= n_sum;
        r_value <= n_value;
        r_clip  <= n_clip;
    end

    assign o_value = r_value;
    assign o_clip  = r_clip;

endmodule

// ----- design/mat4_vertex_transform_top.sv -----
// ----------------------------------------------------------------------------
// mat4_vertex_transform_top
// Fixed-point 4x4 homogeneous vertex transform with a configurable matrix.
//
// A vertex transaction is taken at every rising edge with start high and
// busy low; busy stays low, so one vertex may enter every cycle. Each of
// the four output components comes from its own row pipeline: sixteen
// 16x32 multipliers, two adder levels and a saturation stage. The result
// appears on o_result with o_valid high for exactly one cycle, after the
// product, pair, sum and output registers; results leave in input order
// at one per cycle. The receiver cannot stall the block, so none is ever
// held back. The matrix is written via i_cfg_we, i_cfg_idx and i_cfg_data,
// one column per register; the user must write it only while no vertex
// is in flight, which the block does not enforce. Writes beyond index three
// are ignored. Reset loads the identity matrix and clears all pipeline valid bits.
// ----------------------------------------------------------------------------
module mat4_vertex_transform_top #(
    parameter int COEFF_FRAC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mvt_pkg::t_vertex                    i_vertex,
    output logic                                o_valid,
    output mvt_pkg::t_result                    o_result,
    input  logic                                i_cfg_we,
    input  logic [mvt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mvt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mvt_pkg::*;

    localparam int LAT = 4;

    logic [CFG_DATA_W-1:0] r_col [NUM_COLS];
    logic [LAT-1:0]        r_vld;
    logic [LAT-1:0]        r_last;
    t_comp_vec             w_comp;
    logic signed [COMP_W-1:0] w_value [NUM_ROWS];
    logic [NUM_ROWS-1:0]   w_clip;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0] <= RST_COLUMN_ZERO;
            r_col[1] <= RST_COLUMN_ONE;
            r_col[2] <= RST_COLUMN_TWO;
            r_col[3] <= RST_COLUMN_THREE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COLUMN_ZERO:  r_col[0] <= i_cfg_data;
                REG_COLUMN_ONE:   r_col[1] <= i_cfg_data;
                REG_COLUMN_TWO:   r_col[2] <= i_cfg_data;
                REG_COLUMN_THREE: r_col[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[LAT-2:0], i_vertex.last_in};
    end

    assign w_comp[0] = i_vertex.x_in;
    assign w_comp[1] = i_vertex.y_in;
    assign w_comp[2] = i_vertex.z_in;
    assign w_comp[3] = i_vertex.w_in;

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
        t_coef_row w_coef;
        for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
            assign w_coef[c] = r_col[c][COEF_W*r +: COEF_W];
        end
        mvt_row #(
            .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
        ) u_row (
            .i_clk   (i_clk),
            .i_coef  (w_coef),
            .i_comp  (w_comp),
            .o_value (w_value[r]),
            .o_clip  (w_clip[r])
        );
    end

    assign o_valid            = r_vld[LAT-1];
    assign o_result.x_out     = w_value[0];
    assign o_result.y_out     = w_value[1];
    assign o_result.z_out     = w_value[2];
    assign o_result.w_out     = w_value[3];
    assign o_result.saturated = |w_clip;
    assign o_result.last_out  = r_last[LAT-1];

    // Every accepted vertex produces exactly one result at the end of the pipeline.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result without an accepted transaction");

    a_last_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.last_out == $past(i_vertex.last_in, 4)))
        else $error("last marker not aligned with its transaction");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
            (o_result.x_out == COMP_MAX || o_result.x_out == COMP_MIN ||
             o_result.y_out == COMP_MAX || o_result.y_out == COMP_MIN ||
             o_result.z_out == COMP_MAX || o_result.z_out == COMP_MIN ||
             o_result.w_out == COMP_MAX || o_result.w_out == COMP_MIN))
        else $error("saturation flag set without a clipped component");

endmodule

// ----- dv/mat4_vertex_transform_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mat4_vertex_transform_top_tb
// Self-checking testbench for the 4x4 fixed-point vertex transform. A queue
// of vertex transactions feeds a clocked driver with random gaps. Each
// accepted vertex is transformed by an in-bench copy of the matrix, and the
// monitor compares every result field with the oldest pending prediction.
// Directed vertices cover the component extremes, saturation in both
// directions, floored negative products, the last marker and ignored
// register writes. Random phases then run under several matrices.
// ----------------------------------------------------------------------------
module mat4_vertex_transform_top_tb;

    import mvt_pkg::*;

    localparam int FRAC_BITS      = 12;
    localparam int PIPE_LATENCY   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_VERTICES = 104;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 8'hFF;

    typedef struct packed {
        t_vertex vertex;
        logic    drain_first;
    } t_vertex_job;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            start      = 1'b0;
    t_vertex         i_vertex   = '0;
    logic            i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic            busy;
    logic            o_valid;
    t_result         o_result;

    logic [CFG_DATA_W-1:0] matrix_cols [NUM_COLS];
    t_vertex_job     vertex_q [$];
    t_result         transformed_q [$];
    int unsigned     issued_count = 0;
    int unsigned     result_count = 0;
    int unsigned     error_count  = 0;
    int unsigned     stall_cycles = 0;
    bit              gaps_on      = 1'b1;

    mat4_vertex_transform_top #(
        .COEFF_FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_vertex   (i_vertex),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result transform_vertex(t_vertex v);
        longint                   comp [NUM_COLS];
        longint                   acc;
        logic [COEF_W-1:0]        coef;
        logic signed [COMP_W-1:0] rows [NUM_ROWS];
        t_result                  r;
        comp[0] = longint'($signed(v.x_in));
        comp[1] = longint'($signed(v.y_in));
        comp[2] = longint'($signed(v.z_in));
        comp[3] = longint'($signed(v.w_in));
        r = '0;
        for (int row = 0; row < NUM_ROWS; row++) begin
            acc = 0;
            for (int col = 0; col < NUM_COLS; col++) begin
                coef = matrix_cols[col][row*COEF_W +: COEF_W];
                acc += (longint'($signed(coef)) * comp[col]) >>> FRAC_BITS;
            end
            if (acc > longint'(COMP_MAX)) begin
                acc = longint'(COMP_MAX);
                r.saturated = 1'b1;
            end else if (acc < longint'(COMP_MIN)) begin
                acc = longint'(COMP_MIN);
                r.saturated = 1'b1;
            end
            rows[row] = acc[COMP_W-1:0];
        end
        r.x_out    = rows[0];
        r.y_out    = rows[1];
        r.z_out    = rows[2];
        r.w_out    = rows[3];
        r.last_out = v.last_in;
        return r;
    endfunction

    function automatic void check_field(string name, logic [COMP_W-1:0] want,
                                        logic [COMP_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $error("%s: expected %h, actual %h", name, want, got);
        end
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(int unsigned style);
        logic [COEF_W-1:0] c;
        case (style)
            0: c = COEF_W'($urandom);
            1: c = COEF_W'($urandom_range(0, 8191)) - 16'd4096;
            default: begin
                case ($urandom_range(5))
                    0: c = 16'h7FFF;
                    1: c = 16'h8000;
                    2: c = 16'h0000;
                    3: c = 16'hFFFF;
                    4: c = 16'h0001;
                    default: c = 16'h1000;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [COMP_W-1:0] pick_component(int unsigned style);
        logic [COMP_W-1:0] v;
        case (style)
            0: v = COMP_W'($urandom_range(0, 2097152)) - 32'd1048576;
            1: v = COMP_W'($urandom);
            default: begin
                case ($urandom_range(4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h0001_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic push_vertex(input logic [COMP_W-1:0] x, input logic [COMP_W-1:0] y,
                               input logic [COMP_W-1:0] z, input logic [COMP_W-1:0] w,
                               input logic last, input logic drain);
        t_vertex_job job;
        job.vertex.x_in    = x;
        job.vertex.y_in    = y;
        job.vertex.z_in    = z;
        job.vertex.w_in    = w;
        job.vertex.last_in = last;
        job.drain_first    = drain;
        vertex_q.push_back(job);
        issued_count++;
    endtask

    task automatic wait_drained();
        while (result_count < issued_count)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_column(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx <= REG_COLUMN_THREE)
            matrix_cols[idx[1:0]] = data;
    endtask

    task automatic load_uniform(input logic [COEF_W-1:0] coef);
        wait_drained();
        write_column(REG_COLUMN_ZERO,  {NUM_ROWS{coef}});
        write_column(REG_COLUMN_ONE,   {NUM_ROWS{coef}});
        write_column(REG_COLUMN_TWO,   {NUM_ROWS{coef}});
        write_column(REG_COLUMN_THREE, {NUM_ROWS{coef}});
    endtask

    task automatic load_random_matrix(input int unsigned style);
        logic [CFG_DATA_W-1:0] col;
        int unsigned           s;
        wait_drained();
        for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                s = (style == 3) ? $urandom_range(2) : style;
                col[r*COEF_W +: COEF_W] = pick_coef(s);
            end
            write_column(CFG_IDX_W'(c), col);
        end
        if ($urandom_range(1))
            write_column(CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
    endtask

    // Driver: one transaction per accepted start, gaps drawn at random.
    always @(posedge i_clk) begin
        t_vertex_job job;
        logic        drive_start;
        t_vertex     drive_vertex;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drive_start  = start;
            drive_vertex = i_vertex;
            if (start && !busy) begin
                transformed_q.push_back(transform_vertex(i_vertex));
                drive_start = 1'b0;
            end
            if (!drive_start && vertex_q.size() != 0
                    && !(gaps_on && $urandom_range(99) < 7)) begin
                if (!vertex_q[0].drain_first || transformed_q.size() == 0) begin
                    job          = vertex_q.pop_front();
                    drive_start  = 1'b1;
                    drive_vertex = job.vertex;
                end
            end
            start    <= drive_start;
            i_vertex <= drive_vertex;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            result_count++;
            if (transformed_q.size() == 0) begin
                error_count++;
                $error("result transaction with no vertex pending: %p", o_result);
            end else begin
                want = transformed_q.pop_front();
                check_field("x_out", want.x_out, o_result.x_out);
                check_field("y_out", want.y_out, o_result.y_out);
                check_field("z_out", want.z_out, o_result.z_out);
                check_field("w_out", want.w_out, o_result.w_out);
                check_field("saturated", 32'(want.saturated), 32'(o_result.saturated));
                check_field("last_out", 32'(want.last_out), 32'(o_result.last_out));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("mat4_vertex_transform_top_tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned vstyle;
        matrix_cols[0] = RST_COLUMN_ZERO;
        matrix_cols[1] = RST_COLUMN_ONE;
        matrix_cols[2] = RST_COLUMN_TWO;
        matrix_cols[3] = RST_COLUMN_THREE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The identity matrix from reset passes every component through.
        push_vertex(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
        push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
        push_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_vertex(32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);

        load_uniform(16'h7FFF);
        push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
        push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 1'b0);
        push_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0);

        load_uniform(16'h8000);
        push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
        push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
        push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 1'b0, 1'b0);

        // Tiny coefficients show that negative products round toward minus infinity.
        load_uniform(16'h0001);
        push_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_vertex(32'h1, 32'h1, 32'h1, 32'h1, 1'b0, 1'b0);
        load_uniform(16'hFFFF);
        push_vertex(32'h1, 32'h1, 32'h1, 32'h1, 1'b1, 1'b0);
        push_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);

        // A write beyond the last column must leave the matrix untouched.
        wait_drained();
        write_column(REG_COLUMN_ZERO,  RST_COLUMN_ZERO);
        write_column(REG_COLUMN_ONE,   RST_COLUMN_ONE);
        write_column(REG_COLUMN_TWO,   RST_COLUMN_TWO);
        write_column(REG_COLUMN_THREE, RST_COLUMN_THREE);
        write_column(REG_OUT_OF_RANGE, 64'hDEAD_BEEF_CAFE_F00D);
        push_vertex(32'h0012_3456, 32'hFFED_CBAA, 32'h0000_8000, 32'h0001_0000, 1'b0, 1'b0);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 1'b0, 1'b0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_random_matrix(phase % 4);
            gaps_on = (phase != 3);
            for (int n = 0; n < PHASE_VERTICES; n++) begin
                vstyle = $urandom_range(9);
                vstyle = (vstyle < 4) ? 0 : (vstyle < 8) ? 1 : 2;
                push_vertex(pick_component(vstyle), pick_component(vstyle),
                            pick_component(vstyle), pick_component(vstyle),
                            $urandom_range(15) == 0,
                            (phase == 1 || phase == 5) && n == PHASE_VERTICES / 2);
            end
        end

        wait_drained();
        if (transformed_q.size() != 0) begin
            error_count++;
            $error("%0d vertices never produced a result", transformed_q.size());
        end
        if (error_count == 0)
            $display("mat4_vertex_transform_top_tb OK");
        else
            $display("mat4_vertex_transform_top_tb NOT OK");
        $finish;
    end

endmodule
